>>> rtl/core/tombstone_buffer_with_cursor_defines.svh
// Assertion macros shared by the checker of the tombstone buffer.
`ifndef TOMBSTONE_BUFFER_WITH_CURSOR_DEFINES_SVH
`define TOMBSTONE_BUFFER_WITH_CURSOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tombstone buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tombstone buffer check failed");

`endif

>>> rtl/core/tbc_pkg.sv
// Package with the shared types and codes of the tombstone buffer.
`default_nettype none

package tbc_pkg;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_FIRST  = 3'd1;
    localparam logic [2:0] CMD_NEXT   = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam int CAP_W   = 9;
    localparam int WORD_W  = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_NONE = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CMP_INIT,
        S_CMP_RUN,
        S_ADD_TRY,
        S_SCAN_PRIME,
        S_SCAN_RUN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [WORD_W-1:0] data_in;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] data_out;
        logic [CAP_W-1:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic  load_item;
        logic  cmp_init;
        logic  cmp_step;
        logic  cmp_finish;
        logic  do_add;
        logic  do_remove;
        logic  do_clear;
        logic  cur_zero;
        logic  cur_inc_sat;
        logic  cur_inc;
        logic  set_res;
        stat_t res_status;
        logic  res_take;
        logic  push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       data_zero;
        logic       full;
        logic       removed_nz;
        logic       over_half;
        logic       cmp_done;
        logic       cur_in;
        logic       rd_live;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/tbc_ctrl.sv
// Controller state machine that sequences each command of the tombstone buffer.
`default_nettype none

module tbc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output logic                  cfg_ready,
    input  wire tbc_pkg::dp_stat_t stat,
    output tbc_pkg::ctrl_cmd_t    cmd
);

    tbc_pkg::state_t state_reg;
    tbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = (state_reg != tbc_pkg::S_IDLE);
        cfg_ready  = (state_reg == tbc_pkg::S_IDLE);
        case (state_reg)
            tbc_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = tbc_pkg::S_DECODE;
                end
            end
            tbc_pkg::S_DECODE:
            begin
                case (stat.cmd)
                    tbc_pkg::CMD_ADD:
                    begin
                        if (stat.data_zero)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = tbc_pkg::ST_ZERO;
                            state_next     = tbc_pkg::S_RESULT;
                        end
                        else if (stat.full && stat.removed_nz)
                        begin
                            state_next = tbc_pkg::S_CMP_INIT;
                        end
                        else
                        begin
                            state_next = tbc_pkg::S_ADD_TRY;
                        end
                    end
                    tbc_pkg::CMD_FIRST:
                    begin
                        if (stat.over_half)
                        begin
                            state_next = tbc_pkg::S_CMP_INIT;
                        end
                        else
                        begin
                            state_next = tbc_pkg::S_SCAN_PRIME;
                        end
                    end
                    tbc_pkg::CMD_NEXT:
                    begin
                        state_next = tbc_pkg::S_SCAN_PRIME;
                    end
                    tbc_pkg::CMD_REMOVE:
                    begin
                        cmd.set_res = 1'b1;
                        if (stat.cur_in)
                        begin
                            cmd.do_remove  = 1'b1;
                            cmd.res_status = tbc_pkg::ST_OK;
                        end
                        else
                        begin
                            cmd.res_status = tbc_pkg::ST_NONE;
                        end
                        state_next = tbc_pkg::S_RESULT;
                    end
                    tbc_pkg::CMD_CLEAR:
                    begin
                        cmd.do_clear   = 1'b1;
                        cmd.set_res    = 1'b1;
                        cmd.res_status = tbc_pkg::ST_OK;
                        state_next     = tbc_pkg::S_RESULT;
                    end
                    default:
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = tbc_pkg::ST_OK;
                        state_next     = tbc_pkg::S_RESULT;
                    end
                endcase
            end
            tbc_pkg::S_CMP_INIT:
            begin
                cmd.cmp_init = 1'b1;
                state_next   = tbc_pkg::S_CMP_RUN;
            end
            tbc_pkg::S_CMP_RUN:
            begin
                if (stat.cmp_done)
                begin
                    cmd.cmp_finish = 1'b1;
                    if (stat.cmd == tbc_pkg::CMD_ADD)
                    begin
                        state_next = tbc_pkg::S_ADD_TRY;
                    end
                    else
                    begin
                        state_next = tbc_pkg::S_SCAN_PRIME;
                    end
                end
                else
                begin
                    cmd.cmp_step = 1'b1;
                end
            end
            tbc_pkg::S_ADD_TRY:
            begin
                cmd.set_res = 1'b1;
                if (stat.full)
                begin
                    cmd.res_status = tbc_pkg::ST_FULL;
                end
                else
                begin
                    cmd.do_add     = 1'b1;
                    cmd.res_status = tbc_pkg::ST_OK;
                end
                state_next = tbc_pkg::S_RESULT;
            end
            tbc_pkg::S_SCAN_PRIME:
            begin
                if (stat.cmd == tbc_pkg::CMD_FIRST)
                begin
                    cmd.cur_zero = 1'b1;
                end
                else
                begin
                    cmd.cur_inc_sat = 1'b1;
                end
                state_next = tbc_pkg::S_SCAN_RUN;
            end
            tbc_pkg::S_SCAN_RUN:
            begin
                if (!stat.cur_in)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = tbc_pkg::ST_NONE;
                    state_next     = tbc_pkg::S_RESULT;
                end
                else if (stat.rd_live)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = tbc_pkg::ST_OK;
                    cmd.res_take   = 1'b1;
                    state_next     = tbc_pkg::S_RESULT;
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                end
            end
            tbc_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = tbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tbc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tbc_dpath.sv
// Datapath of the tombstone buffer: slot memory, counters, cursor and result register.
`default_nettype none

module tbc_dpath #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tbc_pkg::item_t                     item,
    input  wire logic                               cfg_we,
    input  wire logic [tbc_pkg::CAP_W-1:0]          cfg_data,
    input  wire logic                               result_stall,
    output logic                                    result_valid,
    output tbc_pkg::result_t                        result,
    input  wire tbc_pkg::ctrl_cmd_t                 cmd,
    output tbc_pkg::dp_stat_t                       stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int KW = (CW > tbc_pkg::CAP_W) ? CW : tbc_pkg::CAP_W;
    localparam int SW = (DATA_WIDTH < tbc_pkg::WORD_W) ? DATA_WIDTH : tbc_pkg::WORD_W;
    localparam logic [CW-1:0] SAT_MAX = CW'(2 * DEPTH - 1);
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

    logic [SW-1:0] slot_mem [DEPTH];

    tbc_pkg::item_t          item_reg;
    logic [KW-1:0]           cap_reg;
    logic [KW-1:0]           cap_next;
    logic [CW-1:0]           used_reg;
    logic [CW-1:0]           used_next;
    logic [CW-1:0]           cursor_reg;
    logic [CW-1:0]           cursor_next;
    logic [CW-1:0]           removed_reg;
    logic [CW-1:0]           removed_next;
    logic [CW-1:0]           cmp_rd_reg;
    logic [CW-1:0]           cmp_rd_next;
    logic [CW-1:0]           cmp_wr_reg;
    logic [CW-1:0]           cmp_wr_next;
    logic [CW-1:0]           newcur_reg;
    logic [CW-1:0]           newcur_next;
    logic [SW-1:0]           rdata_reg;
    logic [1:0]              res_status_reg;
    logic [tbc_pkg::WORD_W-1:0] res_data_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    tbc_pkg::result_t        out_reg;

    logic [KW-1:0]           eff_cap;
    logic [KW-1:0]           new_cap;
    logic [KW-1:0]           new_eff;
    logic [KW-1:0]           used_k;
    logic [SW-1:0]           add_word;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [SW-1:0]           mem_wdata;
    logic [AW-1:0]           mem_raddr;

    assign used_k   = KW'(used_reg);
    assign eff_cap  = (cap_reg > DEPTH_K) ? DEPTH_K : cap_reg;
    assign new_cap  = KW'(cfg_data);
    assign new_eff  = (new_cap > DEPTH_K) ? DEPTH_K : new_cap;
    assign add_word = item_reg.data_in[SW-1:0];

    assign stat.cmd        = item_reg.cmd;
    assign stat.data_zero  = (add_word == '0);
    assign stat.full       = (used_k >= eff_cap);
    assign stat.removed_nz = (removed_reg != '0);
    assign stat.over_half  = (removed_reg > (used_reg >> 1));
    assign stat.cmp_done   = (cmp_rd_reg >= used_reg);
    assign stat.cur_in     = (cursor_reg < used_reg);
    assign stat.rd_live    = (rdata_reg != '0);
    assign stat.out_free   = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        cap_next     = cap_reg;
        used_next    = used_reg;
        cursor_next  = cursor_reg;
        removed_next = removed_reg;
        cmp_rd_next  = cmp_rd_reg;
        cmp_wr_next  = cmp_wr_reg;
        newcur_next  = newcur_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;

        if (cfg_we)
        begin
            cap_next = new_cap;
            if (used_k > new_eff)
            begin
                used_next = new_eff[CW-1:0];
            end
        end

        if (cmd.cmp_init)
        begin
            cmp_rd_next = '0;
            cmp_wr_next = '0;
            newcur_next = '0;
        end

        if (cmd.cmp_step)
        begin
            cmp_rd_next = cmp_rd_reg + CW'(1);
            if (rdata_reg != '0)
            begin
                mem_we      = 1'b1;
                mem_waddr   = cmp_wr_reg[AW-1:0];
                mem_wdata   = rdata_reg;
                cmp_wr_next = cmp_wr_reg + CW'(1);
                if (cmp_rd_reg == cursor_reg)
                begin
                    newcur_next = cmp_wr_reg;
                end
            end
        end

        if (cmd.cmp_finish)
        begin
            used_next    = cmp_wr_reg;
            cursor_next  = newcur_reg;
            removed_next = '0;
        end

        if (cmd.do_add)
        begin
            mem_we    = 1'b1;
            mem_waddr = used_reg[AW-1:0];
            mem_wdata = add_word;
            used_next = used_reg + CW'(1);
        end

        if (cmd.do_remove)
        begin
            mem_we    = 1'b1;
            mem_waddr = cursor_reg[AW-1:0];
            mem_wdata = '0;
            if (removed_reg < SAT_MAX)
            begin
                removed_next = removed_reg + CW'(1);
            end
        end

        if (cmd.do_clear)
        begin
            used_next    = '0;
            removed_next = '0;
            cursor_next  = '0;
        end

        if (cmd.cur_zero)
        begin
            cursor_next = '0;
        end

        if (cmd.cur_inc_sat && (cursor_reg < SAT_MAX))
        begin
            cursor_next = cursor_reg + CW'(1);
        end

        if (cmd.cur_inc)
        begin
            cursor_next = cursor_reg + CW'(1);
        end

        if (cmd.cmp_init || cmd.cmp_step)
        begin
            mem_raddr = cmp_rd_next[AW-1:0];
        end
        else
        begin
            mem_raddr = cursor_next[AW-1:0];
        end

        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slot_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= DEPTH_K;
            used_reg      <= '0;
            cursor_reg    <= '0;
            removed_reg   <= '0;
            cmp_rd_reg    <= '0;
            cmp_wr_reg    <= '0;
            newcur_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            used_reg      <= used_next;
            cursor_reg    <= cursor_next;
            removed_reg   <= removed_next;
            cmp_rd_reg    <= cmp_rd_next;
            cmp_wr_reg    <= cmp_wr_next;
            newcur_reg    <= newcur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_data_reg   <= cmd.res_take ? tbc_pkg::WORD_W'(rdata_reg) : '0;
        end
        if (cmd.push)
        begin
            out_reg.status      <= res_status_reg;
            out_reg.data_out    <= res_data_reg;
            out_reg.entry_count <= used_k[tbc_pkg::CAP_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tombstone_buffer_with_cursor.sv
// Top level of the tombstone buffer: a compacting slot store with an iteration cursor.
// The block works on one transaction at a time and returns one result transaction for
// each command. A rejected zero add, remove, clear and the unused codes set their result
// in the decode state, and an accepted or full add sets it in the add state, after any
// compaction. First and next scan the slot memory one slot per cycle from the cursor,
// passing over at most entry_count slots. A compaction (add on a full store with
// tombstones, or first with more tombstones than half the entries) runs before the add
// or the scan. The slot memory has a single read port and a single write port, which
// sets the scan rate. A new transaction is taken in the cycle after the previous result
// enters the output register; while that result is stalled the next command still runs
// and waits for the output register before its result is written. The slot memory has
// no clearing pass after reset, and the capacity register may be written whenever
// cfg_ready is high.
`default_nettype none

module tombstone_buffer_with_cursor #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire tbc_pkg::item_t            item,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output tbc_pkg::result_t               result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [tbc_pkg::CAP_W-1:0] cfg_data
);

    tbc_pkg::ctrl_cmd_t ctrl_cmd;
    tbc_pkg::dp_stat_t  dp_stat;
    logic               cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    tbc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cfg_ready  (cfg_ready),
        .stat       (dp_stat),
        .cmd        (ctrl_cmd)
    );

    tbc_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (ctrl_cmd),
        .stat         (dp_stat)
    );

endmodule

`default_nettype wire

>>> rtl/core/tbc_check.sv
// Port-level checker of the tombstone buffer and its bind to the top level.
`default_nettype none

`include "tombstone_buffer_with_cursor_defines.svh"

module tbc_check (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire tbc_pkg::result_t result,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready
);

    `TBC_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
    `TBC_ASSERT_NOW(a_cfg_only_idle, cfg_valid && cfg_ready, !item_stall)
    `TBC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
    `TBC_ASSERT_NOW(a_data_only_ok, result_valid && (result.status != tbc_pkg::ST_OK), result.data_out == '0)

endmodule

bind tombstone_buffer_with_cursor tbc_check u_tbc_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

>>> tb/sv/tombstone_store_checker.sv
// Checker for the tombstone buffer: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module tombstone_store_checker
    import tbc_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  item_t            item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  result_t          result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output int               fail_count,
    output int               outstanding,
    output int               checked
);

    localparam int SAT_MAX = 2 * DEPTH - 1;

    logic [WORD_W-1:0] store_mem [DEPTH];
    logic [CAP_W-1:0]  used_q;
    logic [CAP_W-1:0]  walk_ptr;
    logic [CAP_W-1:0]  tomb_cnt;
    logic [CAP_W-1:0]  cap_reg;
    result_t           replies [$];
    int                miss_count;
    int                seen;

    function automatic int usable_slots();
        return (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    endfunction

    task automatic squeeze();
        int w;
        int nc;
        w = 0;
        nc = 0;
        for (int i = 0; i < used_q && i < DEPTH; i++)
        begin
            if (store_mem[i] != '0)
            begin
                if (i == walk_ptr)
                    nc = w;
                store_mem[w] = store_mem[i];
                w++;
            end
        end
        used_q = CAP_W'(w);
        walk_ptr = CAP_W'(nc);
        tomb_cnt = '0;
    endtask

    function automatic bit seek_live(output logic [WORD_W-1:0] found);
        found = '0;
        while (walk_ptr < used_q)
        begin
            if (store_mem[walk_ptr] != '0)
            begin
                found = store_mem[walk_ptr];
                return 1'b1;
            end
            walk_ptr++;
        end
        return 1'b0;
    endfunction

    task automatic step_store(input item_t it, output result_t r);
        stat_t             st;
        logic [WORD_W-1:0] dout;
        st = ST_OK;
        dout = '0;
        case (it.cmd)
            CMD_ADD:
            begin
                if (it.data_in == '0)
                    st = ST_ZERO;
                else
                begin
                    if (used_q >= usable_slots() && tomb_cnt != '0)
                        squeeze();
                    if (used_q >= usable_slots())
                        st = ST_FULL;
                    else
                    begin
                        store_mem[used_q] = it.data_in;
                        used_q++;
                    end
                end
            end
            CMD_FIRST:
            begin
                if (tomb_cnt > used_q / 2)
                    squeeze();
                walk_ptr = '0;
                if (!seek_live(dout))
                    st = ST_NONE;
            end
            CMD_NEXT:
            begin
                if (walk_ptr < SAT_MAX)
                    walk_ptr++;
                if (!seek_live(dout))
                    st = ST_NONE;
            end
            CMD_REMOVE:
            begin
                if (walk_ptr < used_q)
                begin
                    store_mem[walk_ptr] = '0;
                    if (tomb_cnt < SAT_MAX)
                        tomb_cnt++;
                end
                else
                    st = ST_NONE;
            end
            CMD_CLEAR:
            begin
                used_q = '0;
                tomb_cnt = '0;
                walk_ptr = '0;
            end
            default:
            begin
            end
        endcase
        r.status = st;
        r.data_out = dout;
        r.entry_count = used_q;
    endtask

    task automatic check_reply(input result_t got);
        result_t want;
        seen++;
        if (replies.size() == 0)
        begin
            miss_count++;
            if (miss_count <= 10)
                $display("result %0d arrived with none outstanding: status %0d data %h count %0d",
                         seen, got.status, got.data_out, got.entry_count);
        end
        else
        begin
            want = replies.pop_front();
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.entry_count !== want.entry_count)
            begin
                miss_count++;
                if (miss_count <= 10)
                begin
                    $display("result %0d mismatch: expected status %0d data %h count %0d",
                             seen, want.status, want.data_out, want.entry_count);
                    $display("result %0d mismatch: got      status %0d data %h count %0d",
                             seen, got.status, got.data_out, got.entry_count);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        if (!rst_n)
        begin
            used_q = '0;
            walk_ptr = '0;
            tomb_cnt = '0;
            cap_reg = CAP_W'(DEPTH);
            replies.delete();
            miss_count = 0;
            seen = 0;
            fail_count <= 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_reply(result);
            if (cfg_valid && cfg_ready)
            begin
                cap_reg = cfg_data;
                if (used_q > usable_slots())
                    used_q = CAP_W'(usable_slots());
            end
            if (item_valid && !item_stall)
            begin
                step_store(item, r);
                replies.push_back(r);
            end
            fail_count <= miss_count;
            outstanding <= replies.size();
            checked <= seen;
        end
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the tombstone buffer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;
    import tbc_pkg::*;

    localparam int         DEPTH        = 256;
    localparam int         CYCLE_LIMIT  = 4_000_000;
    localparam int         CHOKE_CYCLES = 600;
    localparam int         TOMB_RUN     = 20;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data     = '0;
    logic             hold_off     = 1'b0;
    int               send_gap_pct = 0;
    int               stall_pct    = 0;
    int               sent         = 0;
    int               cycle_count  = 0;
    int               fail_count;
    int               outstanding;
    int               checked;

    tombstone_buffer_with_cursor #(
        .DEPTH(DEPTH),
        .DATA_WIDTH(WORD_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    tombstone_store_checker #(
        .DEPTH(DEPTH)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .outstanding(outstanding),
        .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        int                roll;
        logic [WORD_W-1:0] one_hot;
        roll = $urandom_range(99);
        one_hot = '0;
        one_hot[$urandom_range(WORD_W - 1)] = 1'b1;
        if (roll < 12)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 30)
            return one_hot;
        return $urandom;
    endfunction

    task automatic set_idling(input int gap_pct, input int hold_pct);
        send_gap_pct <= gap_pct;
        stall_pct <= hold_pct;
    endtask

    task automatic send_item(input logic [2:0] c, input logic [WORD_W-1:0] d);
        item_t it;
        it.cmd = c;
        it.data_in = d;
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int add_pct);
        int stop_at;
        int roll;
        int k;
        stop_at = sent + n;
        while (sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < add_pct)
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_item(CMD_ADD, pick_word());
            end
            else if (roll < add_pct + (100 - add_pct) * 3 / 4)
            begin
                send_item(CMD_FIRST, $urandom);
                k = $urandom_range(1, 8);
                repeat (k)
                begin
                    if ($urandom_range(99) < 35)
                        send_item(CMD_REMOVE, $urandom);
                    send_item(CMD_NEXT, $urandom);
                end
            end
            else if (roll < 98)
                send_item(3'($urandom_range(CMD_SPARE_HI)), pick_word());
            else
                send_item(CMD_CLEAR, $urandom);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(38, 86);

        send_item(CMD_NEXT, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_FIRST, '1);
        send_item(CMD_ADD, '0);
        send_item(CMD_ADD, '1);
        send_item(CMD_ADD, 32'h0000_0001);
        send_item(CMD_ADD, 32'h8000_0000);
        send_item(CMD_ADD, 32'h5A5A_A5A5);
        send_item(CMD_FIRST, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_REMOVE, '0);
        // A second remove on the same tombstone still counts toward compaction.
        send_item(CMD_REMOVE, '0);
        send_item(CMD_FIRST, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_SPARE_LO, '1);
        send_item(CMD_SPARE_HI, '0);
        send_item(CMD_CLEAR, '0);

        write_capacity(CAP_W'(2));
        send_item(CMD_ADD, 32'h0000_FFFF);
        send_item(CMD_ADD, 32'hFFFF_0000);
        send_item(CMD_ADD, 32'h1234_5678);
        send_item(CMD_FIRST, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_ADD, 32'h1234_5678);
        send_item(CMD_ADD, 32'h0BAD_F00D);

        write_capacity(CAP_W'(DEPTH));
        run_phase(100, 60);
        write_capacity(CAP_W'(4));
        fork
            begin
                hold_off <= 1'b1;
                repeat (CHOKE_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        run_phase(130, 40);

        set_idling(86, 38);
        write_capacity(CAP_W'(1));
        run_phase(60, 45);
        write_capacity(CAP_W'(0));
        run_phase(25, 50);
        write_capacity(CAP_W'(511));
        run_phase(50, 50);

        set_idling(0, 0);
        write_capacity(CAP_W'(12));
        run_phase(90, 45);

        // Pile removes onto one tombstone, then step the cursor well past the last entry.
        send_item(CMD_CLEAR, '0);
        repeat (12) send_item(CMD_ADD, $urandom | 32'h1);
        send_item(CMD_FIRST, '0);
        repeat (TOMB_RUN) send_item(CMD_REMOVE, $urandom);
        send_item(CMD_FIRST, '0);
        repeat (TOMB_RUN) send_item(CMD_NEXT, $urandom);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_FIRST, '0);

        write_capacity(CAP_W'(DEPTH));
        run_phase(75, 70);

        drain();
        repeat (600) @(posedge clk);
        $display("sent %0d commands and checked %0d results across capacities 0 to 511,",
                 sent, checked);
        $display("with stalls on both sides, a long output hold-off and repeated removes");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tbc_pkg.sv
rtl/core/tbc_ctrl.sv
rtl/core/tbc_dpath.sv
rtl/core/tombstone_buffer_with_cursor.sv
rtl/core/tbc_check.sv
tb/sv/tombstone_store_checker.sv
tb/sv/tb.sv
